>>> rtl/core/dtlb_pkg.sv
// dtlb_pkg: shared types and constants of the data tlb translation unit
// holds beat structs, tlb entry layout, status and register codes
// no dependencies
package dtlb_pkg;

	localparam int DTLB_ENTRIES_DFLT = 32;
	localparam int PAGE_BITS         = 13;
	localparam int VPN_W             = 19;
	localparam int PERM_W            = 4;
	localparam int ADDR_W            = 32;
	localparam int SLOT_IN_W         = 5;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 1;

	localparam logic FN_XLAT  = 1'b0;
	localparam logic FN_WRITE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_XLAT_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USEG_EN  = 2'd2;

	typedef struct packed {
		logic                 func;
		logic [ADDR_W-1:0]    vaddr;
		logic                 is_store;
		logic                 privileged;
		logic [SLOT_IN_W-1:0] entry_index;
		logic                 entry_valid;
		logic [VPN_W-1:0]     entry_vpn;
		logic [VPN_W-1:0]     entry_ppn;
		logic [PERM_W-1:0]    entry_perms;
		logic                 entry_nocache;
	} dtlb_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] paddr;
		logic              uncached;
		logic [1:0]        status;
	} dtlb_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [VPN_W-1:0]  tag;
		logic              nocache;
		logic [PERM_W-1:0] perms;
		logic [VPN_W-1:0]  ppn;
	} dtlb_entry_t;

	typedef struct packed {
		logic xlat_en;
		logic cache_en;
		logic useg_en;
	} dtlb_cfg_t;

endpackage

>>> rtl/core/data_tlb_translate.sv
// data_tlb_translate: data side translation unit, direct mapped tlb, 8 KiB pages
// depends on dtlb_pkg, dtlb_ram, dtlb_check
//
//   channel  signals                        dir  beat
//   req      req_valid, req_stall, req      in   one translate or entry write
//   rsp      rsp_valid, rsp_stall, rsp      out  one result per translate beat
//   cfg      cfg_we, cfg_idx, cfg_wdata     in   one register write, no wait
//
// a translate beat goes from the ram read into the read stage, then through check
// logic into the result register; one beat per cycle sustained while rsp is not stalled
// an entry write completes at its accept edge and gives no result
// after reset a clearing pass over every ram entry zeroes the ram; req is stalled
// a stalled result holds the read stage, which then stalls req
// TLB_ENTRIES must be a power of two
module data_tlb_translate
	import dtlb_pkg::*;
#(
	parameter int TLB_ENTRIES = DTLB_ENTRIES_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  dtlb_req_t             req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output dtlb_rsp_t             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TLB_ENTRIES);

	dtlb_cfg_t               cfg_q;
	logic                    clr_busy_q;
	logic [IDX_W-1:0]        clr_cnt_q;

	logic                    valid_s1;
	logic [ADDR_W-1:0]       vaddr_s1;
	logic                    is_store_s1;
	logic                    priv_s1;

	logic                    rsp_valid_s2;
	dtlb_rsp_t               rsp_s2;

	logic                    take;
	logic                    xlat_take;
	logic                    wr_take;
	logic                    adv_s1;
	logic [IDX_W+SLOT_IN_W-1:0] wr_slot_ext;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	dtlb_entry_t             ram_wdata;
	dtlb_entry_t             new_entry;
	dtlb_entry_t             rd_entry;
	dtlb_rsp_t               chk_rsp;

	assign adv_s1    = valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = clr_busy_q || (valid_s1 && !adv_s1);
	assign take      = req_valid && !req_stall;
	assign xlat_take = take && (req.func == FN_XLAT);
	assign wr_take   = take && (req.func == FN_WRITE);

	assign wr_slot_ext = {{IDX_W{1'b0}}, req.entry_index};

	always_comb begin
		new_entry         = '0;
		new_entry.valid   = req.entry_valid;
		new_entry.tag     = req.entry_vpn;
		new_entry.nocache = req.entry_nocache;
		new_entry.perms   = req.entry_perms;
		new_entry.ppn     = req.entry_ppn;
	end

	// clearing pass owns the write port until done
	assign ram_we    = clr_busy_q || wr_take;
	assign ram_waddr = clr_busy_q ? clr_cnt_q : wr_slot_ext[IDX_W-1:0];
	assign ram_wdata = clr_busy_q ? dtlb_entry_t'('0) : new_entry;

	dtlb_ram #(
		.WIDTH ($bits(dtlb_entry_t)),
		.DEPTH (TLB_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (xlat_take),
		.raddr (req.vaddr[PAGE_BITS+IDX_W-1:PAGE_BITS]),
		.rdata (rd_entry)
	);

	dtlb_check u_check (
		.entry      (rd_entry),
		.vaddr      (vaddr_s1),
		.is_store   (is_store_s1),
		.privileged (priv_s1),
		.cfg        (cfg_q),
		.rsp        (chk_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_XLAT_EN:  cfg_q.xlat_en  <= cfg_wdata[0];
				REG_CACHE_EN: cfg_q.cache_en <= cfg_wdata[0];
				REG_USEG_EN:  cfg_q.useg_en  <= cfg_wdata[0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(TLB_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (xlat_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xlat_take) begin
			vaddr_s1    <= req.vaddr;
			is_store_s1 <= req.is_store;
			priv_s1     <= req.privileged;
		end
		if (adv_s1) begin
			rsp_s2 <= chk_rsp;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTH
	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> req_stall)
		else $error("req beat taken during clearing pass");

	a_zero_addr_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != ST_OK)) |-> (rsp.paddr == '0))
		else $error("nonzero paddr on miss or fault");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_MISS ||
			rsp.status == ST_FAULT))
		else $error("bad status code");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid && rsp_stall) |=> (valid_s1 && $stable(vaddr_s1)))
		else $error("read stage lost while result stalled");
`endif

endmodule

>>> rtl/core/dtlb_ram.sv
// dtlb_ram: generic single write port, single read port ram
// read data is registered; no reset on the array
// no dependencies
module dtlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/dtlb_check.sv
// dtlb_check: tag compare, permission check and address forming
// combinational logic between the read stage and the result register
// depends on dtlb_pkg
module dtlb_check
	import dtlb_pkg::*;
(
	input  dtlb_entry_t       entry,
	input  logic [ADDR_W-1:0] vaddr,
	input  logic              is_store,
	input  logic              privileged,
	input  dtlb_cfg_t         cfg,
	output dtlb_rsp_t         rsp
);

	logic [VPN_W-1:0] vpn;
	logic [1:0]       need;
	logic             hit;

	assign vpn  = vaddr[ADDR_W-1:PAGE_BITS];
	assign need = {privileged, is_store};
	assign hit  = entry.valid && (entry.tag == vpn);

	always_comb begin
		rsp = '0;
		rsp.status = ST_OK;
		if (cfg.xlat_en) begin
			if (!hit) begin
				rsp.status = ST_MISS;
			end else if (!entry.perms[need]) begin
				rsp.status = ST_FAULT;
			end else begin
				rsp.paddr    = {entry.ppn, vaddr[PAGE_BITS-1:0]};
				rsp.uncached = entry.nocache || (cfg.useg_en && !entry.ppn[VPN_W-1]);
			end
		end else begin
			rsp.paddr    = vaddr;
			rsp.uncached = cfg.useg_en && !vaddr[ADDR_W-1];
		end
		if (!cfg.cache_en) begin
			rsp.uncached = 1'b1;
		end
	end

endmodule

>>> dv/tb.sv
// tb: self-checking bench for data_tlb_translate, covering entry writes and translations
// keeps its own tlb and register copy to predict each result beat, with random idling
// depends on dtlb_pkg and the data_tlb_translate rtl
module tb;
	import dtlb_pkg::*;

	localparam int SLOT_W      = $clog2(DTLB_ENTRIES_DFLT);
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYC  = 4;
	localparam int MAX_WAIT    = 13;
	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 80;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam logic [VPN_W-1:0] HIGH_VPN = 19'h7FFE5;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	dtlb_req_t             req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	dtlb_rsp_t             rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	dtlb_entry_t tlb_copy [DTLB_ENTRIES_DFLT];
	dtlb_cfg_t   cfg_copy = '0;
	dtlb_rsp_t   xlat_rsp_q [$];
	dtlb_rsp_t   rsp_want;
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;

	data_tlb_translate #(
		.TLB_ENTRIES(DTLB_ENTRIES_DFLT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("data_tlb_translate test failed");
		$finish;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic dtlb_rsp_t predict_xlat(input dtlb_req_t b);
		dtlb_rsp_t         r;
		dtlb_entry_t       e;
		logic [VPN_W-1:0]  vpn;
		r = '0;
		r.status = ST_OK;
		if (cfg_copy.xlat_en) begin
			vpn = b.vaddr[ADDR_W-1:PAGE_BITS];
			e = tlb_copy[vpn[SLOT_W-1:0]];
			if (!e.valid || e.tag != vpn) begin
				r.status = ST_MISS;
			end else if (!e.perms[{b.privileged, b.is_store}]) begin
				r.status = ST_FAULT;
			end else begin
				r.paddr = {e.ppn, b.vaddr[PAGE_BITS-1:0]};
				r.uncached = e.nocache | (cfg_copy.useg_en & ~e.ppn[VPN_W-1]);
			end
		end else begin
			r.paddr = b.vaddr;
			r.uncached = cfg_copy.useg_en & ~b.vaddr[ADDR_W-1];
		end
		if (!cfg_copy.cache_en) begin
			r.uncached = 1'b1;
		end
		return r;
	endfunction

	function automatic void store_entry(input dtlb_req_t b);
		dtlb_entry_t e;
		e.valid = b.entry_valid;
		e.tag = b.entry_vpn;
		e.nocache = b.entry_nocache;
		e.perms = b.entry_perms;
		e.ppn = b.entry_ppn;
		tlb_copy[b.entry_index[SLOT_W-1:0]] = e;
	endfunction

	function automatic dtlb_req_t rand_beat();
		logic [95:0] w;
		w = {$urandom, $urandom, $urandom};
		return w[$bits(dtlb_req_t)-1:0];
	endfunction

	function automatic dtlb_req_t xlat_beat(input logic [ADDR_W-1:0] va, input logic st,
			input logic pv);
		dtlb_req_t b;
		b = rand_beat();
		b.func = FN_XLAT;
		b.vaddr = va;
		b.is_store = st;
		b.privileged = pv;
		return b;
	endfunction

	function automatic dtlb_req_t entry_beat(input logic [SLOT_IN_W-1:0] idx, input logic vld,
			input logic [VPN_W-1:0] vpn, input logic [VPN_W-1:0] ppn,
			input logic [PERM_W-1:0] perms, input logic nc);
		dtlb_req_t b;
		b = rand_beat();
		b.func = FN_WRITE;
		b.entry_index = idx;
		b.entry_valid = vld;
		b.entry_vpn = vpn;
		b.entry_ppn = ppn;
		b.entry_perms = perms;
		b.entry_nocache = nc;
		return b;
	endfunction

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// result side: check each accepted beat, then stall for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (xlat_rsp_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result beat, expected none, actual %h %b %0d",
					$time, rsp.paddr, rsp.uncached, rsp.status);
			end else begin
				rsp_want = xlat_rsp_q.pop_front();
				check_field("paddr", rsp_want.paddr, rsp.paddr);
				check_field("uncached", ADDR_W'(rsp_want.uncached), ADDR_W'(rsp.uncached));
				check_field("status", ADDR_W'(rsp_want.status), ADDR_W'(rsp.status));
			end
			stall_left = draw_wait();
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_beat(input dtlb_req_t b);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (b.func == FN_WRITE) begin
			store_entry(b);
		end else begin
			xlat_rsp_q.push_back(predict_xlat(b));
		end
	endtask

	task automatic quiesce();
		req_valid <= 1'b0;
		while (xlat_rsp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_XLAT_EN: begin
				cfg_copy.xlat_en = val;
			end
			REG_CACHE_EN: begin
				cfg_copy.cache_en = val;
			end
			REG_USEG_EN: begin
				cfg_copy.useg_en = val;
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic xe, input logic ce, input logic ue);
		quiesce();
		write_reg(REG_XLAT_EN, xe);
		write_reg(REG_CACHE_EN, ce);
		write_reg(REG_USEG_EN, ue);
	endtask

	task automatic test_pass_through();
		set_mode(1'b0, 1'b1, 1'b0);
		send_beat(xlat_beat(32'h0000_0000, 1'b0, 1'b0));
		send_beat(xlat_beat(32'hFFFF_FFFF, 1'b1, 1'b1));
		set_mode(1'b0, 1'b1, 1'b1);
		send_beat(xlat_beat(32'h7FFF_FFFF, 1'b0, 1'b1));
		send_beat(xlat_beat(32'h8000_0000, 1'b1, 1'b0));
		set_mode(1'b0, 1'b0, 1'b1);
		send_beat(xlat_beat(32'h8000_0000, 1'b0, 1'b0));
		send_beat(xlat_beat(32'h0000_0000, 1'b1, 1'b1));
	endtask

	task automatic test_perm_check();
		set_mode(1'b1, 1'b1, 1'b1);
		// read-only page in both modes
		send_beat(entry_beat(5'd5, 1'b1, HIGH_VPN, 19'h7FFFF, 4'b0101, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h1FFF}, 1'b0, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h1FFF}, 1'b1, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h0000}, 1'b0, 1'b1));
		send_beat(xlat_beat({HIGH_VPN, 13'h0000}, 1'b1, 1'b1));
		// write-only page in the low segment
		send_beat(entry_beat(5'd5, 1'b1, HIGH_VPN, 19'h00000, 4'b1010, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h0ABC}, 1'b0, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h0ABC}, 1'b1, 1'b0));
		send_beat(xlat_beat({HIGH_VPN, 13'h1FFF}, 1'b1, 1'b1));
	endtask

	task automatic test_miss_cases();
		set_mode(1'b1, 1'b0, 1'b0);
		send_beat(xlat_beat({HIGH_VPN ^ 19'h40000, 13'h0000}, 1'b0, 1'b1));
		send_beat(entry_beat(5'd0, 1'b1, 19'h00000, 19'h12345, 4'b1111, 1'b1));
		send_beat(xlat_beat(32'h0000_1FFF, 1'b1, 1'b0));
		// an entry written with its valid bit clear must miss
		send_beat(entry_beat(5'd0, 1'b0, 19'h00000, 19'h12345, 4'b1111, 1'b1));
		send_beat(xlat_beat(32'h0000_0000, 1'b0, 1'b0));
		set_mode(1'b1, 1'b1, 1'b0);
		send_beat(xlat_beat({19'h7FFFF, 13'h0000}, 1'b1, 1'b1));
		send_beat(entry_beat(5'd31, 1'b1, 19'h7FFFF, 19'h7FFFF, 4'b1111, 1'b1));
		send_beat(xlat_beat({19'h7FFFF, 13'h1FFF}, 1'b1, 1'b1));
	endtask

	task automatic test_reg_index();
		set_mode(1'b0, 1'b1, 1'b0);
		write_reg(REG_NONE, 1'b1);
		send_beat(xlat_beat(32'h0000_0000, 1'b0, 1'b0));
	endtask

	task automatic test_random();
		dtlb_req_t   b;
		dtlb_entry_t e;
		int          pick;
		for (int p = 0; p < PHASES; p++) begin
			calm = (p % 3 == 2);
			if (p < 8) begin
				set_mode(p[0], p[1], p[2]);
			end else begin
				set_mode(1'b1, 1'b1, p[0]);
			end
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (i == PHASE_BEATS / 2) begin
					quiesce();
				end
				b = rand_beat();
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					b.func = FN_WRITE;
					// mostly entries whose tag lands in their own slot
					if (pick < 22) begin
						b.entry_vpn[SLOT_W-1:0] = b.entry_index[SLOT_W-1:0];
					end
					b.entry_valid = (pick % 8 != 0);
				end else begin
					b.func = FN_XLAT;
					e = tlb_copy[b.vaddr[PAGE_BITS +: SLOT_W]];
					if (e.valid && pick < 80) begin
						b.vaddr[ADDR_W-1:PAGE_BITS] = e.tag;
					end else if (e.valid && pick < 88) begin
						b.vaddr[ADDR_W-1:PAGE_BITS] =
							e.tag ^ (VPN_W'(1) << $urandom_range(SLOT_W, VPN_W - 1));
					end
				end
				send_beat(b);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < DTLB_ENTRIES_DFLT; i++) begin
			tlb_copy[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_pass_through();
		test_perm_check();
		test_miss_cases();
		test_reg_index();
		test_random();
		quiesce();
		if (err_cnt == 0) begin
			$display("data_tlb_translate test passed");
		end else begin
			$display("data_tlb_translate test failed");
		end
		$finish;
	end

endmodule
